// File: rtl/core/source_text_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// source_text_tokenizer_defines
// Assertion macros used by the tokenizer checker. Each macro expects
// signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define STT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define STT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types, codes and record builders shared by the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int POS_BITS = 16;
  typedef logic [POS_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = '1;

  localparam logic [7:0] MAX_LEXEME = 8'd255;
  localparam int MAX_RECS = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Scanner modes.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_ESCAPE = 3'd4;

  // Token kinds.
  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_SINGLE = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // Record kinds.
  localparam logic REC_LEXEME = 1'b0;
  localparam logic REC_CLOSE  = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_DIGIT_0    = 8'h30;
  localparam logic [7:0] CH_DIGIT_9    = 8'h39;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_marker;
  } src_item_t;

  typedef struct packed {
    logic       record_kind;
    logic [7:0] lexeme_byte;
    logic [2:0] token_kind;
    pos_t       start_line;
    pos_t       start_column;
    logic [7:0] byte_count;
    logic       was_truncated;
    logic       last_of_run;
  } tok_item_t;

  typedef logic [1:0] rec_count_t;

  // All records caused by one source byte, oldest in entry 0.
  typedef struct packed {
    rec_count_t                count;
    tok_item_t [MAX_RECS-1:0]  recs;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == POS_MAX) ? v : pos_t'(v + pos_t'(1));
  endfunction

  function automatic tok_item_t mk_lex(input logic [7:0] b, input logic [2:0] kind,
                                       input pos_t ln, input pos_t col,
                                       input logic [7:0] idx);
    tok_item_t r;
    r               = '0;
    r.record_kind   = REC_LEXEME;
    r.lexeme_byte   = b;
    r.token_kind    = kind;
    r.start_line    = ln;
    r.start_column  = col;
    r.byte_count    = idx;
    return r;
  endfunction

  function automatic tok_item_t mk_close(input logic [2:0] kind, input pos_t ln,
                                         input pos_t col, input logic [7:0] cnt,
                                         input logic trunc);
    tok_item_t r;
    r               = '0;
    r.record_kind   = REC_CLOSE;
    r.token_kind    = kind;
    r.start_line    = ln;
    r.start_column  = col;
    r.byte_count    = cnt;
    r.was_truncated = trunc;
    return r;
  endfunction

  function automatic tok_item_t mk_end(input pos_t ln, input pos_t col);
    tok_item_t r;
    r              = '0;
    r.record_kind  = REC_CLOSE;
    r.token_kind   = KIND_END;
    r.start_line   = ln;
    r.start_column = col;
    return r;
  endfunction

endpackage

// File: rtl/core/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-serial lexical analyser producing lexeme and token closing records.
//
//   channel  direction  payload     handshake
//   text     in         src_item_t  text_valid / text_stall
//   token    out        tok_item_t  token_valid / token_stall
//
// A source byte is taken every cycle while the bundle queue has room; each
// byte yields zero to three records, queued as one bundle.
// Records leave one per cycle while token_stall is low; a byte's records go
// out in order, first through the bundle queue and then the output register.
// text_stall rises only when all QUEUE_DEPTH bundle slots are full.
// There is no clearing pass on reset.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int QUEUE_DEPTH = stt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_stall,
  input  stt_pkg::src_item_t text_item,
  output logic               token_valid,
  input  logic               token_stall,
  output stt_pkg::tok_item_t token_item
);
  import stt_pkg::*;

  bundle_t       new_bundle, head_bundle;
  queue_status_t status;
  logic          accept, push, pop;

  assign text_stall = status.full;
  assign accept     = text_valid && !status.full;
  assign push       = accept && (new_bundle.count != '0);

  stt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (text_item),
    .bundle (new_bundle)
  );

  stt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_bundle (new_bundle),
    .pop       (pop),
    .rd_bundle (head_bundle),
    .status    (status)
  );

  stt_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head_bundle),
    .status (status),
    .pop    (pop),
    .valid  (token_valid),
    .stall  (token_stall),
    .item   (token_item)
  );

endmodule

// File: rtl/core/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Scanner: classifies each source byte against the current mode, updates
// the position and token state, and forms the records that byte causes.
// ----------------------------------------------------------------------------
module stt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  stt_pkg::src_item_t item,
  output stt_pkg::bundle_t   bundle
);
  import stt_pkg::*;

  logic [2:0] mode, mode_next;
  pos_t       line, line_next;
  pos_t       col, col_next;
  pos_t       tok_line, tok_line_next;
  pos_t       tok_col, tok_col_next;
  logic [7:0] stored, stored_next;
  logic       ovf, ovf_next;

  logic [7:0] b;
  logic       is_alpha, is_digit, is_space, ident_member, number_member;
  pos_t       col_inc;
  logic [2:0] open_kind;
  logic       room;

  // Outcome of treating the byte as the first byte outside any token.
  logic       ib_token;
  logic [2:0] ib_mode;
  rec_count_t ib_n;
  tok_item_t  ib_r0, ib_r1;
  pos_t       ib_line, ib_col;
  logic [7:0] ib_stored;

  // String mode: the byte's own store step before any close.
  logic [7:0] str_stored;
  logic       str_ovf;

  assign b             = item.text_byte;
  assign is_alpha      = (b inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]});
  assign is_digit      = (b inside {[CH_DIGIT_0:CH_DIGIT_9]});
  assign is_space      = (b == CH_SPACE) || (b inside {[CH_TAB:CH_CR]});
  assign ident_member  = is_alpha || is_digit || (b == CH_UNDERSCORE);
  assign number_member = is_digit || (b == CH_DOT);
  assign col_inc       = sat_inc(col);
  assign room          = (stored < MAX_LEXEME);

  always_comb begin
    case (mode)
      MODE_IDENT:  open_kind = KIND_IDENT;
      MODE_NUMBER: open_kind = KIND_NUMBER;
      default:     open_kind = KIND_STRING;
    endcase
  end

  always_comb begin
    ib_token  = 1'b0;
    ib_mode   = MODE_IDLE;
    ib_n      = '0;
    ib_r0     = '0;
    ib_r1     = '0;
    ib_line   = line;
    ib_col    = col;
    ib_stored = 8'd1;
    if (is_space) begin
      if (b == CH_NEWLINE) begin
        ib_line = sat_inc(line);
        ib_col  = '0;
      end else begin
        ib_col = col_inc;
      end
    end else begin
      ib_token = 1'b1;
      ib_col   = col_inc;
      if (is_alpha || b == CH_UNDERSCORE) begin
        ib_mode = MODE_IDENT;
        ib_r0   = mk_lex(b, KIND_IDENT, line, col, 8'd0);
        ib_n    = 2'd1;
      end else if (is_digit) begin
        ib_mode = MODE_NUMBER;
        ib_r0   = mk_lex(b, KIND_NUMBER, line, col, 8'd0);
        ib_n    = 2'd1;
      end else if (b == CH_QUOTE) begin
        ib_mode = MODE_STRING;
        ib_r0   = mk_lex(b, KIND_STRING, line, col, 8'd0);
        ib_n    = 2'd1;
      end else begin
        // A single-byte token opens and closes on the same byte.
        ib_r0     = mk_lex(b, KIND_SINGLE, line, col, 8'd0);
        ib_r1     = mk_close(KIND_SINGLE, line, col, 8'd1, 1'b0);
        ib_n      = 2'd2;
        ib_stored = 8'd0;
      end
    end
  end

  assign str_stored = room ? 8'(stored + 8'd1) : stored;
  assign str_ovf    = room ? ovf : 1'b1;

  always_comb begin
    mode_next     = mode;
    line_next     = line;
    col_next      = col;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    stored_next   = stored;
    ovf_next      = ovf;
    bundle        = '0;
    if (item.end_marker) begin
      if (mode inside {MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_ESCAPE}) begin
        bundle.recs[0] = mk_close(open_kind, tok_line, tok_col, stored, ovf);
        bundle.recs[1] = mk_end(line, col);
        bundle.count   = 2'd2;
        stored_next    = '0;
        ovf_next       = 1'b0;
      end else begin
        bundle.recs[0] = mk_end(line, col);
        bundle.count   = 2'd1;
      end
      line_next = pos_t'(1);
      col_next  = '0;
      mode_next = MODE_IDLE;
    end else begin
      case (mode)
        MODE_IDENT, MODE_NUMBER: begin
          if ((mode == MODE_IDENT) ? ident_member : number_member) begin
            if (room) begin
              bundle.recs[0] = mk_lex(b, open_kind, tok_line, tok_col, stored);
              bundle.count   = 2'd1;
              stored_next    = 8'(stored + 8'd1);
            end else begin
              ovf_next = 1'b1;
            end
            col_next = col_inc;
          end else begin
            // The terminating byte closes the token and is then scanned afresh.
            bundle.recs[0] = mk_close(open_kind, tok_line, tok_col, stored, ovf);
            bundle.recs[1] = ib_r0;
            bundle.recs[2] = ib_r1;
            bundle.count   = 2'(2'd1 + ib_n);
            mode_next      = ib_mode;
            line_next      = ib_line;
            col_next       = ib_col;
            ovf_next       = 1'b0;
            stored_next    = ib_token ? ib_stored : 8'd0;
            if (ib_token) begin
              tok_line_next = line;
              tok_col_next  = col;
            end
          end
        end
        MODE_STRING, MODE_ESCAPE: begin
          col_next    = col_inc;
          stored_next = str_stored;
          ovf_next    = str_ovf;
          if (room) begin
            bundle.recs[0] = mk_lex(b, KIND_STRING, tok_line, tok_col, stored);
            bundle.count   = 2'd1;
          end
          if (mode == MODE_ESCAPE) begin
            mode_next = MODE_STRING;
          end else if (b == CH_QUOTE) begin
            if (room) begin
              bundle.recs[1] = mk_close(KIND_STRING, tok_line, tok_col, str_stored, str_ovf);
              bundle.count   = 2'd2;
            end else begin
              bundle.recs[0] = mk_close(KIND_STRING, tok_line, tok_col, str_stored, str_ovf);
              bundle.count   = 2'd1;
            end
            mode_next   = MODE_IDLE;
            stored_next = '0;
            ovf_next    = 1'b0;
          end else if (b == CH_BACKSLASH) begin
            mode_next = MODE_ESCAPE;
          end
        end
        default: begin
          bundle.recs[0] = ib_r0;
          bundle.recs[1] = ib_r1;
          bundle.count   = ib_n;
          mode_next      = ib_mode;
          line_next      = ib_line;
          col_next       = ib_col;
          if (ib_token) begin
            tok_line_next = line;
            tok_col_next  = col;
            stored_next   = ib_stored;
            ovf_next      = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      line     <= pos_t'(1);
      col      <= '0;
      tok_line <= pos_t'(1);
      tok_col  <= '0;
      stored   <= '0;
      ovf      <= 1'b0;
    end else if (accept) begin
      mode     <= mode_next;
      line     <= line_next;
      col      <= col_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      stored   <= stored_next;
      ovf      <= ovf_next;
    end
  end

endmodule

// File: rtl/core/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Short queue of record bundles between the scanner and the serialiser.
// ----------------------------------------------------------------------------
module stt_queue #(
  parameter int DEPTH = stt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  stt_pkg::bundle_t       wr_bundle,
  input  logic                   pop,
  output stt_pkg::bundle_t       rd_bundle,
  output stt_pkg::queue_status_t status
);
  import stt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t       entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  assign rd_bundle    = entries[rd_ptr];
  assign status.full  = (fill == CW'(DEPTH));
  assign status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      case ({push, pop})
        2'b10:   fill <= CW'(fill + 1'b1);
        2'b01:   fill <= CW'(fill - 1'b1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/core/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// Serialiser: walks the head bundle into the output register one record
// per cycle unless stalled, and marks the last record of each bundle.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic                   clk,
  input  logic                   rst,
  input  stt_pkg::bundle_t       head,
  input  stt_pkg::queue_status_t status,
  output logic                   pop,
  output logic                   valid,
  input  logic                   stall,
  output stt_pkg::tok_item_t     item
);
  import stt_pkg::*;

  logic [1:0] idx;
  logic       load, last;
  tok_item_t  rec;

  // The output register is refilled whenever it is empty or being taken and the queue holds a bundle.
  assign load = !status.empty && (!valid || !stall);
  assign last = (2'(idx + 2'd1) == head.count);
  assign pop  = load && last;

  always_comb begin
    rec             = head.recs[idx];
    rec.last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= last ? 2'd0 : 2'(idx + 2'd1);
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= rec;
    end
  end

endmodule

// File: rtl/core/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the token channel of the tokenizer, bound to the top.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_defines.svh"

module stt_checker (
  input logic               clk,
  input logic               rst,
  input logic               token_valid,
  input logic               token_stall,
  input stt_pkg::tok_item_t token_item
);
  import stt_pkg::*;

  // A stalled transaction stays offered and unchanged.
  `STT_ASSERT_NXT(a_stall_hold, token_valid && token_stall, token_valid && $stable(token_item), "stalled token transaction changed")

  // The end-of-input record carries no length and always finishes its run.
  `STT_ASSERT_IMP(a_end_record, token_valid && token_item.record_kind == REC_CLOSE && token_item.token_kind == KIND_END, token_item.byte_count == 8'd0 && !token_item.was_truncated && token_item.last_of_run, "malformed end record")

  // Lexeme records never report truncation and never carry the end kind.
  `STT_ASSERT_IMP(a_lexeme_record, token_valid && token_item.record_kind == REC_LEXEME, !token_item.was_truncated && token_item.token_kind != KIND_END, "malformed lexeme record")

  // Closing records carry no lexeme byte.
  `STT_ASSERT_IMP(a_close_byte, token_valid && token_item.record_kind == REC_CLOSE, token_item.lexeme_byte == 8'd0, "closing record carries a byte")

endmodule

bind source_text_tokenizer stt_checker u_checker (.*);

// File: bench/source_text_tokenizer_test.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_test
// Self-checking bench for the byte-serial tokenizer. Source bytes are sent in
// random bursts and every record that the block returns is compared with the
// records predicted by a behavioural scanner kept inside the bench. The run
// covers a directed set of tokens, a long token past the lexeme limit and a
// random stream of mostly well-formed tokens mixed with noise.
// ----------------------------------------------------------------------------
module source_text_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_style_e;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      text_valid = 1'b0;
  logic      text_stall;
  src_item_t text_item = '0;
  logic      token_valid;
  logic      token_stall = 1'b0;
  tok_item_t token_item;

  src_item_t text_backlog[$];
  tok_item_t awaited_records[$];
  tok_item_t run_recs[$];
  bit        failed = 1'b0;
  bit        text_taken = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        queued_count = 0;

  rx_style_e rx_style = RX_OPEN;
  int        rx_left = 0;
  int        hold_left = 0;
  bit        hold_request = 1'b0;

  // Scanner state of the prediction.
  logic [2:0] lex_mode = MODE_IDLE;
  pos_t       cur_line = pos_t'(1);
  pos_t       cur_col = '0;
  pos_t       tok_line = pos_t'(1);
  pos_t       tok_col = '0;
  logic [7:0] lex_len = '0;
  logic       lex_over = 1'b0;

  source_text_tokenizer i_dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_item   (text_item),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_item  (token_item)
  );

  always #10 clk = ~clk;

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_DIGIT_0 && b <= CH_DIGIT_9;
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic void advance_column();
    if (cur_col != POS_MAX) cur_col = cur_col + pos_t'(1);
  endfunction

  function automatic logic [2:0] open_kind();
    if (lex_mode == MODE_IDENT) return KIND_IDENT;
    if (lex_mode == MODE_NUMBER) return KIND_NUMBER;
    return KIND_STRING;
  endfunction

  function automatic void push_rec(input logic rk, input logic [7:0] b,
                                   input logic [2:0] tk, input pos_t ln,
                                   input pos_t col, input logic [7:0] cnt,
                                   input logic trunc);
    tok_item_t r;
    r               = '0;
    r.record_kind   = rk;
    r.lexeme_byte   = b;
    r.token_kind    = tk;
    r.start_line    = ln;
    r.start_column  = col;
    r.byte_count    = cnt;
    r.was_truncated = trunc;
    run_recs.push_back(r);
  endfunction

  // Bytes beyond the lexeme limit are dropped but remembered as truncation.
  function automatic void keep_byte(input logic [7:0] b, input logic [2:0] kind);
    if (lex_len < MAX_LEXEME) begin
      push_rec(REC_LEXEME, b, kind, tok_line, tok_col, lex_len, 1'b0);
      lex_len = lex_len + 8'd1;
    end else begin
      lex_over = 1'b1;
    end
  endfunction

  function automatic void finish_token(input logic [2:0] kind);
    push_rec(REC_CLOSE, 8'd0, kind, tok_line, tok_col, lex_len, lex_over);
    lex_mode = MODE_IDLE;
    lex_len  = '0;
    lex_over = 1'b0;
  endfunction

  function automatic void begin_token(input logic [7:0] b);
    if (is_blank(b)) begin
      if (b == CH_NEWLINE) begin
        if (cur_line != POS_MAX) cur_line = cur_line + pos_t'(1);
        cur_col = '0;
      end else begin
        advance_column();
      end
    end else begin
      tok_line = cur_line;
      tok_col  = cur_col;
      advance_column();
      lex_len  = '0;
      lex_over = 1'b0;
      if (is_letter(b) || b == CH_UNDERSCORE) begin
        lex_mode = MODE_IDENT;
        keep_byte(b, KIND_IDENT);
      end else if (is_digit(b)) begin
        lex_mode = MODE_NUMBER;
        keep_byte(b, KIND_NUMBER);
      end else if (b == CH_QUOTE) begin
        lex_mode = MODE_STRING;
        keep_byte(b, KIND_STRING);
      end else begin
        keep_byte(b, KIND_SINGLE);
        finish_token(KIND_SINGLE);
      end
    end
  endfunction

  // Works out every record caused by one accepted source transaction.
  function automatic void scan_item(input src_item_t it);
    logic [7:0] b;
    bit         member;
    b = it.text_byte;
    run_recs.delete();
    if (it.end_marker) begin
      if (lex_mode != MODE_IDLE) finish_token(open_kind());
      push_rec(REC_CLOSE, 8'd0, KIND_END, cur_line, cur_col, 8'd0, 1'b0);
      cur_line = pos_t'(1);
      cur_col  = '0;
      lex_mode = MODE_IDLE;
    end else if (lex_mode == MODE_IDENT || lex_mode == MODE_NUMBER) begin
      member = (lex_mode == MODE_IDENT) ? (is_letter(b) || is_digit(b) || b == CH_UNDERSCORE)
                                        : (is_digit(b) || b == CH_DOT);
      if (member) begin
        keep_byte(b, open_kind());
        advance_column();
      end else begin
        // The terminating byte is scanned again as the start of what follows.
        finish_token(open_kind());
        begin_token(b);
      end
    end else if (lex_mode == MODE_STRING || lex_mode == MODE_ESCAPE) begin
      keep_byte(b, KIND_STRING);
      advance_column();
      if (lex_mode == MODE_ESCAPE) lex_mode = MODE_STRING;
      else if (b == CH_QUOTE) finish_token(KIND_STRING);
      else if (b == CH_BACKSLASH) lex_mode = MODE_ESCAPE;
    end else begin
      begin_token(b);
    end
    if (run_recs.size() != 0) run_recs[$].last_of_run = 1'b1;
    foreach (run_recs[i]) awaited_records.push_back(run_recs[i]);
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  function automatic void check_record(input tok_item_t got);
    tok_item_t want;
    if (awaited_records.size() == 0) begin
      $error("record arrived with none predicted: %p", got);
      failed = 1'b1;
    end else begin
      want = awaited_records.pop_front();
      compare_field("record_kind", want.record_kind, got.record_kind);
      compare_field("lexeme_byte", want.lexeme_byte, got.lexeme_byte);
      compare_field("token_kind", want.token_kind, got.token_kind);
      compare_field("start_line", want.start_line, got.start_line);
      compare_field("start_column", want.start_column, got.start_column);
      compare_field("byte_count", want.byte_count, got.byte_count);
      compare_field("was_truncated", want.was_truncated, got.was_truncated);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
    end
  endfunction

  // Monitor: both channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      text_taken <= 1'b0;
    end else begin
      text_taken <= text_valid && !text_stall;
      if (text_valid && !text_stall) scan_item(text_item);
      if (token_valid && !token_stall) check_record(token_item);
    end
  end

  // Driver: a held transaction stays put until it has been taken.
  always @(negedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (!text_valid || text_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        text_valid <= 1'b0;
      end else if (text_backlog.size() != 0) begin
        text_item  <= text_backlog.pop_front();
        text_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
        end else begin
          burst_left--;
        end
      end else begin
        text_valid <= 1'b0;
      end
    end
  end

  // Receiver: a changing stall style, and one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      token_stall <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 80;
      end
      if (hold_left != 0) begin
        hold_left--;
        token_stall <= 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_style = rx_style_e'($urandom_range(0, 3));
          rx_left  = $urandom_range(16, 160);
        end else begin
          rx_left--;
        end
        case (rx_style)
          RX_OPEN:  token_stall <= 1'b0;
          RX_LIGHT: token_stall <= ($urandom_range(0, 7) == 0);
          RX_HALF:  token_stall <= ($urandom_range(0, 1) == 1);
          default:  token_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  task automatic add_byte(input logic [7:0] b);
    src_item_t it;
    it.text_byte  = b;
    it.end_marker = 1'b0;
    text_backlog.push_back(it);
    queued_count++;
  endtask

  task automatic add_end();
    src_item_t it;
    it.text_byte  = 8'($urandom_range(0, 255));
    it.end_marker = 1'b1;
    text_backlog.push_back(it);
    queued_count++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] word_char(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'(CH_UPPER_A + r);
    if (r < 52) return 8'(CH_LOWER_A + r - 26);
    if (r == 52) return CH_UNDERSCORE;
    return 8'(CH_DIGIT_0 + r - 53);
  endfunction

  task automatic add_string(input int len);
    logic [7:0] c;
    add_byte(CH_QUOTE);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          add_byte(CH_BACKSLASH);
          add_byte(8'($urandom_range(0, 255)));
        end
        1: add_byte(CH_NEWLINE);
        default: begin
          c = 8'($urandom_range(32, 126));
          if (c == CH_QUOTE || c == CH_BACKSLASH) c = CH_UNDERSCORE;
          add_byte(c);
        end
      endcase
    end
    // Now and then the string is left open and swallows what follows.
    if ($urandom_range(0, 9) != 0) add_byte(CH_QUOTE);
  endtask

  task automatic add_random_token();
    string ops = "+-*/=(){};,<>!&|#";
    int    len;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        len = $urandom_range(0, 9);
        add_byte(word_char(1'b1));
        for (int i = 0; i < len; i++) add_byte(word_char(1'b0));
      end
      4, 5, 6: begin
        len = $urandom_range(0, 6);
        add_byte(8'(CH_DIGIT_0 + $urandom_range(0, 9)));
        for (int i = 0; i < len; i++)
          add_byte(($urandom_range(0, 3) == 0) ? CH_DOT : 8'(CH_DIGIT_0 + $urandom_range(0, 9)));
      end
      7, 8: add_string($urandom_range(0, 8));
      9, 10: begin
        if ($urandom_range(0, 2) == 0) add_byte(8'($urandom_range(128, 255)));
        else add_byte(ops[$urandom_range(0, ops.len() - 1)]);
      end
      11, 12, 13, 14: begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
          add_byte(($urandom_range(0, 1) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
      end
      15, 16, 17: add_byte(8'($urandom_range(0, 255)));
      default: add_end();
    endcase
    if ($urandom_range(0, 1) == 0) add_byte(CH_SPACE);
  endtask

  task automatic wait_until_quiet();
    while (text_backlog.size() != 0 || text_valid) @(posedge clk);
    while (awaited_records.size() != 0) @(posedge clk);
  endtask

  initial begin
    int mark;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed tokens: every kind, each way of closing a token, and odd bytes.
    add_text("_a9Z 09.5.x+");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(CH_TAB);
    add_byte(CH_CR);
    add_byte(8'h0B);
    add_byte(8'h0C);
    add_byte(CH_NEWLINE);
    add_text("\"a\\\"\n\"");
    add_end();
    add_text("abc");
    add_end();
    add_text("\"x\\");
    add_end();
    add_text("\"q");
    add_end();
    add_text("12");
    add_end();
    // An identifier longer than the lexeme limit, then a token after it.
    for (int i = 0; i < 260; i++) add_byte(word_char(1'b0) == CH_UNDERSCORE ? 8'h61 : 8'h62);
    add_text("+");
    add_end();
    wait_until_quiet();

    // Random stream; the long receiver hold-off lands while items keep coming.
    hold_request = 1'b1;
    mark = queued_count;
    add_string(12);
    while (queued_count - mark < 30) add_random_token();
    add_end();
    wait_until_quiet();
    mark = queued_count;
    while (queued_count - mark < 20) add_random_token();
    add_end();
    wait_until_quiet();

    repeat (20) @(posedge clk);
    if (failed || awaited_records.size() != 0) begin
      $display("Simulation FAILED");
    end else begin
      $display("Simulation PASSED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/stt_pkg.sv
rtl/core/stt_front.sv
rtl/core/stt_queue.sv
rtl/core/stt_back.sv
rtl/core/source_text_tokenizer.sv
rtl/core/stt_checker.sv
bench/source_text_tokenizer_test.sv
